/* rtl/core/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the least-squares slope unit
// Widths of the running sums, the shared multiplier and the finalize
// accumulator, plus the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int XW      = 16;  // x_value, y_value
  localparam int SlopeW  = 32;  // Q16.16 result
  localparam int SumXW   = 29;  // sum of x, sum of y
  localparam int SumXXW  = 43;  // sum of x*x, unsigned
  localparam int SumXYW  = 44;  // sum of x*y, signed
  localparam int MulW    = 30;  // shared multiplier operand width, signed
  localparam int ProdW   = 2 * MulW;
  localparam int SplitW  = 22;  // low part of a wide sum fed to the multiplier
  localparam int AccW    = 58;  // numerator / denominator accumulator, signed
  localparam int MagW    = 57;  // magnitude of the numerator
  localparam int DenW    = 56;  // positive denominator
  localparam int PreW    = 24;  // numerator bits handled by the early compare
  localparam int RndW    = 9;   // 8 bits of Q8.8 to Q16.16 scale plus a round bit
  localparam int QW      = MagW - PreW; // quotient bits, 33

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_XX_IN,
    MUL_XY,
    MUL_SX_SY,
    MUL_N_SXY_LO,
    MUL_N_SXY_HI,
    MUL_SX_SX,
    MUL_N_SXX_LO,
    MUL_N_SXX_HI
  } mul_sel_t;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_LOAD_NEG,
    FIN_ADD,
    FIN_ADD_HI,
    FIN_SAVE_LOAD_NEG
  } fin_op_t;

  typedef struct packed {
    logic     capture;    // latch the incoming point
    logic     point_add;  // count the point, add x, y, x*x
    logic     sxy_add;    // add the x*y product
    mul_sel_t mul_sel;
    fin_op_t  fin_op;
    logic     div_start;
    logic     out_load;   // move the quotient into the output register
    logic     clear;      // zero the sums for the next run
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/lss_point_if.sv */
// ----------------------------------------------------------------------------
// lss_point_if: point request channel
// One (x, y) point per request, with a flag on the last point of a run.
// ----------------------------------------------------------------------------
interface lss_point_if;
  logic                             valid;
  logic                             ready;
  logic signed [lss_pkg::XW-1:0]    x_value;
  logic signed [lss_pkg::XW-1:0]    y_value;
  logic                             last_point;

  modport source (output valid, output x_value, output y_value, output last_point,
                  input ready);
  modport sink (input valid, input x_value, input y_value, input last_point,
                output ready);
endinterface

/* rtl/core/lss_slope_if.sv */
// ----------------------------------------------------------------------------
// lss_slope_if: slope result channel
// One fitted slope per run, with a flag for a degenerate run.
// ----------------------------------------------------------------------------
interface lss_slope_if;
  logic                               valid;
  logic                               ready;
  logic signed [lss_pkg::SlopeW-1:0]  slope;
  logic                               degenerate;

  modport source (output valid, output slope, output degenerate, input ready);
  modport sink (input valid, input slope, input degenerate, output ready);
endinterface

/* rtl/core/lss_div.sv */
// ----------------------------------------------------------------------------
// lss_div: rounded Q16.16 divider
// Restoring division of |num| * 512 by den, one quotient bit per cycle,
// then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module lss_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              bad,
  input  logic signed [lss_pkg::AccW-1:0]   num,
  input  logic signed [lss_pkg::AccW-1:0]   den,
  output logic                              done,
  output logic signed [lss_pkg::SlopeW-1:0] slope,
  output logic                              degenerate
);

  localparam int CntW = $clog2(lss_pkg::QW);
  localparam logic [lss_pkg::QW-1:0] LimPos = lss_pkg::QW'(64'(2) ** 31 - 1);
  localparam logic [lss_pkg::QW-1:0] LimNeg = lss_pkg::QW'(64'(2) ** 31);
  localparam logic [lss_pkg::SlopeW-1:0] SlopeMax = {1'b0, {(lss_pkg::SlopeW-1){1'b1}}};
  localparam logic [lss_pkg::SlopeW-1:0] SlopeMin = {1'b1, {(lss_pkg::SlopeW-1){1'b0}}};

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} dstate_t;

  dstate_t                    state;
  logic                       neg;
  logic [lss_pkg::DenW-1:0]   den_reg;
  logic [lss_pkg::DenW-1:0]   rem;
  logic [lss_pkg::QW-1:0]     shift;
  logic [lss_pkg::QW-1:0]     quo;
  logic [CntW-1:0]            cnt;

  logic [lss_pkg::AccW-1:0]   mag_full;
  logic [lss_pkg::MagW-1:0]   mag;
  logic [lss_pkg::DenW-1:0]   den_pos;
  logic                       sat;
  logic [lss_pkg::DenW:0]     rem_shift;
  logic [lss_pkg::DenW:0]     rem_diff;
  logic                       qbit;
  logic [lss_pkg::QW:0]       q_inc;
  logic [lss_pkg::QW-1:0]     q_rnd;
  logic [lss_pkg::QW-1:0]     q_lim;
  logic [lss_pkg::QW-1:0]     q_sat;

  always_comb begin
    mag_full  = num[lss_pkg::AccW-1] ? lss_pkg::AccW'(-num) : lss_pkg::AccW'(num);
    mag       = mag_full[lss_pkg::MagW-1:0];
    den_pos   = den[lss_pkg::DenW-1:0];
    // quotient would need more than QW bits: saturate without iterating
    sat       = {{(lss_pkg::DenW-lss_pkg::QW){1'b0}}, mag[lss_pkg::MagW-1:lss_pkg::PreW]}
                >= den_pos;
    rem_shift = {rem, shift[lss_pkg::QW-1]};
    rem_diff  = rem_shift - {1'b0, den_reg};
    qbit      = rem_shift >= {1'b0, den_reg};
    q_inc     = {1'b0, quo} + (lss_pkg::QW+1)'(1);
    q_rnd     = q_inc[lss_pkg::QW:1];
    q_lim     = neg ? LimNeg : LimPos;
    q_sat     = (q_rnd > q_lim) ? q_lim : q_rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg     <= num[lss_pkg::AccW-1];
            den_reg <= den_pos;
            if (bad || den <= 0) begin
              slope      <= '0;
              degenerate <= 1'b1;
              done       <= 1'b1;
            end else if (sat) begin
              slope      <= num[lss_pkg::AccW-1] ? SlopeMin : SlopeMax;
              degenerate <= 1'b0;
              done       <= 1'b1;
            end else begin
              rem   <= {{(lss_pkg::DenW-lss_pkg::QW){1'b0}},
                        mag[lss_pkg::MagW-1:lss_pkg::PreW]};
              shift <= {mag[lss_pkg::PreW-1:0], {lss_pkg::RndW{1'b0}}};
              quo   <= '0;
              cnt   <= '0;
              done  <= 1'b0;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (qbit) begin
            rem <= rem_diff[lss_pkg::DenW-1:0];
          end else begin
            rem <= rem_shift[lss_pkg::DenW-1:0];
          end
          quo   <= {quo[lss_pkg::QW-2:0], qbit};
          shift <= {shift[lss_pkg::QW-2:0], 1'b0};
          cnt   <= cnt + CntW'(1);
          if (cnt == CntW'(lss_pkg::QW - 1)) begin
            state <= D_ROUND;
          end
        end
        D_ROUND: begin
          slope      <= neg ? -q_sat[lss_pkg::SlopeW-1:0] : q_sat[lss_pkg::SlopeW-1:0];
          degenerate <= 1'b0;
          done       <= 1'b1;
          state      <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/lss_dp.sv */
// ----------------------------------------------------------------------------
// lss_dp: least-squares slope datapath
// Running sums, one shared 30x30 multiplier, the numerator and denominator
// accumulator, the divider and the output register.
// ----------------------------------------------------------------------------
module lss_dp #(
  parameter int MaxPoints = 4096,
  parameter int CountW    = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lss_pkg::dp_cmd_t                  cmd,
  output lss_pkg::dp_status_t               status,
  input  logic signed [lss_pkg::XW-1:0]     x_in,
  input  logic signed [lss_pkg::XW-1:0]     y_in,
  input  logic                              last_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lss_pkg::SlopeW-1:0] out_slope,
  output logic                              out_degenerate
);

  localparam logic [CountW-1:0] CountMax  = CountW'(MaxPoints);
  localparam logic [CountW-1:0] CountOver = CountW'(MaxPoints + 1);
  localparam int HiXYW = lss_pkg::SumXYW - lss_pkg::SplitW;
  localparam int HiXXW = lss_pkg::SumXXW - lss_pkg::SplitW;

  logic signed [lss_pkg::XW-1:0]     x_reg;
  logic signed [lss_pkg::XW-1:0]     y_reg;
  logic                              last_reg;
  logic [CountW-1:0]                 count;
  logic                              take;
  logic signed [lss_pkg::SumXW-1:0]  sum_x;
  logic signed [lss_pkg::SumXW-1:0]  sum_y;
  logic [lss_pkg::SumXXW-1:0]        sum_xx;
  logic signed [lss_pkg::SumXYW-1:0] sum_xy;
  logic signed [lss_pkg::ProdW-1:0]  prod;
  logic signed [lss_pkg::AccW-1:0]   acc;
  logic signed [lss_pkg::AccW-1:0]   num;

  logic signed [lss_pkg::MulW-1:0]   mul_a;
  logic signed [lss_pkg::MulW-1:0]   mul_b;
  logic signed [lss_pkg::MulW-1:0]   n_ext;
  logic signed [lss_pkg::AccW-1:0]   prod_acc;
  logic                              overflow;

  logic                              div_done;
  logic signed [lss_pkg::SlopeW-1:0] div_slope;
  logic                              div_degenerate;

  always_comb begin
    n_ext    = {{(lss_pkg::MulW-CountW){1'b0}}, count};
    prod_acc = prod[lss_pkg::AccW-1:0];
    overflow = count == CountOver;
    mul_a    = '0;
    mul_b    = '0;
    unique case (cmd.mul_sel)
      lss_pkg::MUL_XX_IN: begin
        mul_a = {{(lss_pkg::MulW-lss_pkg::XW){x_in[lss_pkg::XW-1]}}, x_in};
        mul_b = mul_a;
      end
      lss_pkg::MUL_XY: begin
        mul_a = {{(lss_pkg::MulW-lss_pkg::XW){x_reg[lss_pkg::XW-1]}}, x_reg};
        mul_b = {{(lss_pkg::MulW-lss_pkg::XW){y_reg[lss_pkg::XW-1]}}, y_reg};
      end
      lss_pkg::MUL_SX_SY: begin
        mul_a = {{(lss_pkg::MulW-lss_pkg::SumXW){sum_x[lss_pkg::SumXW-1]}}, sum_x};
        mul_b = {{(lss_pkg::MulW-lss_pkg::SumXW){sum_y[lss_pkg::SumXW-1]}}, sum_y};
      end
      lss_pkg::MUL_SX_SX: begin
        mul_a = {{(lss_pkg::MulW-lss_pkg::SumXW){sum_x[lss_pkg::SumXW-1]}}, sum_x};
        mul_b = mul_a;
      end
      lss_pkg::MUL_N_SXY_LO: begin
        mul_a = n_ext;
        mul_b = {{(lss_pkg::MulW-lss_pkg::SplitW){1'b0}}, sum_xy[lss_pkg::SplitW-1:0]};
      end
      lss_pkg::MUL_N_SXY_HI: begin
        mul_a = n_ext;
        mul_b = {{(lss_pkg::MulW-HiXYW){sum_xy[lss_pkg::SumXYW-1]}},
                 sum_xy[lss_pkg::SumXYW-1:lss_pkg::SplitW]};
      end
      lss_pkg::MUL_N_SXX_LO: begin
        mul_a = n_ext;
        mul_b = {{(lss_pkg::MulW-lss_pkg::SplitW){1'b0}}, sum_xx[lss_pkg::SplitW-1:0]};
      end
      lss_pkg::MUL_N_SXX_HI: begin
        mul_a = n_ext;
        mul_b = {{(lss_pkg::MulW-HiXXW){1'b0}}, sum_xx[lss_pkg::SumXXW-1:lss_pkg::SplitW]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_reg    <= x_in;
      y_reg    <= y_in;
      last_reg <= last_in;
    end
    if (cmd.mul_sel != lss_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.fin_op)
      lss_pkg::FIN_LOAD_NEG: acc <= -prod_acc;
      lss_pkg::FIN_ADD:      acc <= acc + prod_acc;
      lss_pkg::FIN_ADD_HI:   acc <= acc + (prod_acc <<< lss_pkg::SplitW);
      lss_pkg::FIN_SAVE_LOAD_NEG: begin
        num <= acc;
        acc <= -prod_acc;
      end
      default: acc <= acc;
    endcase
    if (cmd.out_load) begin
      out_slope      <= div_slope;
      out_degenerate <= div_degenerate;
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count  <= '0;
      take   <= 1'b0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_xy <= '0;
    end else begin
      if (cmd.point_add) begin
        take <= count < CountMax;
        if (count < CountMax) begin
          count  <= count + CountW'(1);
          sum_x  <= sum_x + lss_pkg::SumXW'(x_reg);
          sum_y  <= sum_y + lss_pkg::SumXW'(y_reg);
          sum_xx <= sum_xx + prod[lss_pkg::SumXXW-1:0];
        end else begin
          count <= CountOver;
        end
      end
      if (cmd.sxy_add && take) begin
        sum_xy <= sum_xy + prod[lss_pkg::SumXYW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  lss_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .bad        (overflow),
    .num        (num),
    .den        (acc),
    .done       (div_done),
    .slope      (div_slope),
    .degenerate (div_degenerate)
  );

  always_comb begin
    status.last     = last_reg;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

/* rtl/core/lss_ctrl.sv */
// ----------------------------------------------------------------------------
// lss_ctrl: least-squares slope controller
// Sequences the shared multiplier per point, the finalize products on the
// last point, the divider and the hand-off to the output register.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lss_pkg::dp_status_t status,
  output lss_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_XY, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_START, S_DIV
  } state_t;

  state_t state;
  state_t state_next;
  logic   pending;  // x*y product of the previous point not yet added

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = lss_pkg::MUL_NONE;
    cmd.fin_op     = lss_pkg::FIN_NONE;
    in_ready       = 1'b0;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.sxy_add = pending;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.mul_sel = lss_pkg::MUL_XX_IN;
          state_next  = S_XY;
        end
      end
      S_XY: begin
        cmd.point_add = 1'b1;
        cmd.mul_sel   = lss_pkg::MUL_XY;
        state_next    = status.last ? S_F0 : S_IDLE;
      end
      S_F0: begin
        cmd.sxy_add = 1'b1;
        cmd.mul_sel = lss_pkg::MUL_SX_SY;
        state_next  = S_F1;
      end
      S_F1: begin
        cmd.fin_op  = lss_pkg::FIN_LOAD_NEG;
        cmd.mul_sel = lss_pkg::MUL_N_SXY_LO;
        state_next  = S_F2;
      end
      S_F2: begin
        cmd.fin_op  = lss_pkg::FIN_ADD;
        cmd.mul_sel = lss_pkg::MUL_N_SXY_HI;
        state_next  = S_F3;
      end
      S_F3: begin
        cmd.fin_op  = lss_pkg::FIN_ADD_HI;
        cmd.mul_sel = lss_pkg::MUL_SX_SX;
        state_next  = S_F4;
      end
      S_F4: begin
        // numerator complete: park it, start the denominator
        cmd.fin_op  = lss_pkg::FIN_SAVE_LOAD_NEG;
        cmd.mul_sel = lss_pkg::MUL_N_SXX_LO;
        state_next  = S_F5;
      end
      S_F5: begin
        cmd.fin_op  = lss_pkg::FIN_ADD;
        cmd.mul_sel = lss_pkg::MUL_N_SXX_HI;
        state_next  = S_F6;
      end
      S_F6: begin
        cmd.fin_op = lss_pkg::FIN_ADD_HI;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        // hold until the output register can take the result
        if (status.div_done && status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= (state == S_XY) && !status.last;
    end
  end

endmodule

/* rtl/core/least_squares_slope_unit.sv */
// ----------------------------------------------------------------------------
// least_squares_slope_unit: least-squares slope of a run of points
// Accumulates n, Sx, Sy, Sxx and Sxy over a run and, on the last point,
// returns (n*Sxy - Sx*Sy) / (n*Sxx - Sx*Sx) in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   points: one (x_value, y_value) request per point, last_point set on the
//   final point of a run. The shared multiplier forms x*x in the accept
//   cycle and x*y in the next, and ready stays low while x*y is formed,
//   so a new point is taken only after that step.
//   result: one request per run carrying slope and degenerate. After the
//   last point, the finalize products and then the divider follow; the
//   divider does not iterate when the run is degenerate or the slope
//   saturates before dividing. The divider resolves one quotient bit per
//   cycle (33 bits).
//   A run beyond MAX_POINTS points or with all x equal gives slope 0 and
//   degenerate 1. Sums clear when the result enters the output register.
//   The output register lets the next run accumulate while a result waits;
//   a second result waits in the divider until the first is taken, with no
//   points accepted meanwhile.
//   Reset (rst, synchronous) clears the sums and drops any pending result.
// ----------------------------------------------------------------------------
module least_squares_slope_unit #(
  parameter int MAX_POINTS = 4096
) (
  input  logic         clk,
  input  logic         rst,
  lss_point_if.sink    points,
  lss_slope_if.source  result
);

  localparam int CountW = $clog2(MAX_POINTS + 2);

  lss_pkg::dp_cmd_t    cmd;
  lss_pkg::dp_status_t status;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lss_dp #(
    .MaxPoints (MAX_POINTS),
    .CountW    (CountW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .x_in           (points.x_value),
    .y_in           (points.y_value),
    .last_in        (points.last_point),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_slope      (result.slope),
    .out_degenerate (result.degenerate)
  );

endmodule
